// ===== hdl/dsrp_pkg.sv =====
`timescale 1ns / 1ps

package dsrp_pkg;

  // input word kinds, carried on tuser
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_GOALS = 2'd1,
    OP_ENABLE    = 2'd2,
    OP_DISABLE   = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_RAMP_DIVIDER  = 2'd0,
    CFG_RAMP_STEP     = 2'd1,
    CFG_MAX_SPEED     = 2'd2,
    CFG_STEPS_PER_REV = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned StepW     = 15;
  localparam int unsigned SpeedMaxW = 15;
  localparam int unsigned SprW      = 13;

  localparam logic [15:0]          RampDivRst = 16'd50;
  localparam logic [StepW-1:0]     RampStpRst = 15'd50;
  localparam logic [SpeedMaxW-1:0] MaxSpdRst  = 15'd5000;
  localparam logic [SprW-1:0]      SprRst     = 13'd200;

  // rate = spr * |speed| / 1000 ; period = (1e6 / rate) / 20 = 50000 / rate
  localparam int unsigned ProdW   = SprW + SpeedMaxW;
  localparam int unsigned DivDsrW = 19;
  localparam int unsigned PerW    = 16;
  localparam int unsigned PerNum  = 1000000 / 20;

  // x / 1000 = ((x >> 3) * ceil(2^32 / 125)) >> 32, exact for x below 2^28
  localparam int unsigned          RecipPre  = 3;
  localparam int unsigned          RecipPost = 32;
  localparam int unsigned          RecipMulW = 26;
  localparam logic [RecipMulW-1:0] RecipMul  = 26'd34359739;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RATE,
    ST_RATE_CHK,
    ST_PER_WAIT,
    ST_COUNT
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic count;
    logic out_load;
    logic mul;
    logic rate_ld;
    logic div_start;
    logic per_wr;
    logic sel;
  } cmd_t;

  typedef struct packed {
    logic tick;
    logic changed;
    logic div_done;
    logic rate_zero;
  } status_t;

endpackage

// ===== hdl/dsrp_div.sv =====
`timescale 1ns / 1ps

module dsrp_div #(
  parameter int unsigned DividendW = dsrp_pkg::PerW,
  parameter int unsigned DivisorW  = dsrp_pkg::DivDsrW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic [DividendW-1:0] quo_o,
  output logic                 done_o
);

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dsr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q, done_q;
  logic [DivisorW:0]    r_sh, r_nx;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    r_sh  = {rem_q, quo_q[DividendW-1]};
    ge    = r_sh >= {1'b0, dsr_q};
    r_nx  = ge ? r_sh - {1'b0, dsr_q} : r_sh;
    rem_d = r_nx[DivisorW-1:0];
    quo_d = {quo_q[DividendW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DividendW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ===== hdl/dsrp_dp.sv =====
`timescale 1ns / 1ps

module dsrp_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  logic [1:0]            op_i,
  input  logic signed [15:0]    goal_a_i,
  input  logic signed [15:0]    goal_b_i,
  input  dsrp_pkg::cmd_t        cmd_i,
  output dsrp_pkg::status_t     st_o,
  output logic [4:0]            out_o
);

  localparam int unsigned RecipW = dsrp_pkg::ProdW - dsrp_pkg::RecipPre + dsrp_pkg::RecipMulW;

  function automatic logic signed [15:0] ramp_toward(input logic signed [15:0] now,
                                                     input logic signed [15:0] goal,
                                                     input logic [14:0] step);
    logic signed [16:0] now_x, goal_x, step_x, up, dn, res;
    now_x  = 17'(now);
    goal_x = 17'(goal);
    step_x = $signed({2'b00, step});
    up     = now_x + step_x;
    dn     = now_x - step_x;
    res    = now_x;
    if (now < goal) begin
      res = (up > goal_x) ? goal_x : up;
    end else if (now > goal) begin
      res = (dn < goal_x) ? goal_x : dn;
    end
    return res[15:0];
  endfunction

  // config registers
  logic [15:0]                        ramp_div_q;
  logic [dsrp_pkg::StepW-1:0]         ramp_step_q;
  logic [dsrp_pkg::SpeedMaxW-1:0]     max_speed_q;
  logic [dsrp_pkg::SprW-1:0]          spr_q;

  logic [15:0]        ramp_count_q;
  logic signed [15:0] now_a_q, now_b_q, goal_a_q, goal_b_q;
  logic [15:0]        period_a_q, period_b_q;
  logic [16:0]        cnt_a_q, cnt_b_q;
  logic               dir_a_q, dir_b_q, disabled_q;
  logic [dsrp_pkg::ProdW-1:0]   prod_q;
  logic [dsrp_pkg::DivDsrW-1:0] rate_q;
  logic [4:0]         out_q;

  dsrp_pkg::op_e      op;
  logic [15:0]        rc_inc;
  logic               adjust, changed;
  logic signed [15:0] na, nb, spd;
  logic [15:0]        mag;
  logic [dsrp_pkg::SpeedMaxW-1:0] mag_c;
  logic [16:0]        cnt_a_d, cnt_b_d;
  logic               step_a, step_b, disabled_nx;
  logic [RecipW-1:0]            recip;
  logic [dsrp_pkg::DivDsrW-1:0] rate_d;
  logic [dsrp_pkg::PerW-1:0]    div_quo, per_val;
  logic               div_done, rate_zero;

  always_comb begin
    op      = dsrp_pkg::op_e'(op_i);
    rc_inc  = (ramp_count_q != 16'hFFFF) ? ramp_count_q + 16'd1 : ramp_count_q;
    adjust  = rc_inc >= ramp_div_q;
    na      = ramp_toward(now_a_q, goal_a_q, ramp_step_q);
    nb      = ramp_toward(now_b_q, goal_b_q, ramp_step_q);
    changed = adjust && ((na != now_a_q) || (nb != now_b_q));
  end

  // speed magnitude for the selected channel, clamped to max_speed
  always_comb begin
    spd   = cmd_i.sel ? now_b_q : now_a_q;
    mag   = spd[15] ? 16'(-spd) : 16'(spd);
    mag_c = (mag > {1'b0, max_speed_q}) ? max_speed_q : mag[14:0];
  end

  // step counters; an idle channel parks its counter at -1
  always_comb begin
    cnt_a_d = cnt_a_q + 17'd1;
    step_a  = 1'b0;
    if (period_a_q == '0) begin
      cnt_a_d = '1;
    end else if ($signed(cnt_a_d) >= $signed({1'b0, period_a_q})) begin
      cnt_a_d = '0;
      step_a  = 1'b1;
    end
    cnt_b_d = cnt_b_q + 17'd1;
    step_b  = 1'b0;
    if (period_b_q == '0) begin
      cnt_b_d = '1;
    end else if ($signed(cnt_b_d) >= $signed({1'b0, period_b_q})) begin
      cnt_b_d = '0;
      step_b  = 1'b1;
    end
  end

  always_comb begin
    disabled_nx = disabled_q;
    if (cmd_i.accept && op == dsrp_pkg::OP_DISABLE) disabled_nx = 1'b1;
    if (cmd_i.accept && op == dsrp_pkg::OP_ENABLE)  disabled_nx = 1'b0;
  end

  // /1000 by reciprocal multiply; 50000 / rate on the serial divider
  always_comb begin
    recip     = RecipW'(prod_q[dsrp_pkg::ProdW-1:dsrp_pkg::RecipPre])
              * RecipW'(dsrp_pkg::RecipMul);
    rate_d    = recip[dsrp_pkg::RecipPost +: dsrp_pkg::DivDsrW];
    rate_zero = (rate_q == '0);
    per_val   = rate_zero ? '0 : div_quo;
  end

  dsrp_div #(
    .DividendW (dsrp_pkg::PerW),
    .DivisorW  (dsrp_pkg::DivDsrW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dsrp_pkg::PerW'(dsrp_pkg::PerNum)),
    .divisor_i  (rate_q),
    .quo_o      (div_quo),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_div_q   <= dsrp_pkg::RampDivRst;
      ramp_step_q  <= dsrp_pkg::RampStpRst;
      max_speed_q  <= dsrp_pkg::MaxSpdRst;
      spr_q        <= dsrp_pkg::SprRst;
      ramp_count_q <= '0;
      now_a_q      <= '0;
      now_b_q      <= '0;
      goal_a_q     <= '0;
      goal_b_q     <= '0;
      period_a_q   <= '0;
      period_b_q   <= '0;
      cnt_a_q      <= '0;
      cnt_b_q      <= '0;
      dir_a_q      <= 1'b0;
      dir_b_q      <= 1'b0;
      disabled_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (dsrp_pkg::cfg_idx_e'(cfg_index_i))
          dsrp_pkg::CFG_RAMP_DIVIDER:  ramp_div_q  <= cfg_data_i;
          dsrp_pkg::CFG_RAMP_STEP:     ramp_step_q <= cfg_data_i[14:0];
          dsrp_pkg::CFG_MAX_SPEED:     max_speed_q <= cfg_data_i[14:0];
          dsrp_pkg::CFG_STEPS_PER_REV: spr_q       <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      disabled_q <= disabled_nx;
      if (cmd_i.accept) begin
        case (op)
          dsrp_pkg::OP_SET_GOALS: begin
            goal_a_q <= goal_a_i;
            goal_b_q <= goal_b_i;
          end
          dsrp_pkg::OP_DISABLE: begin
            now_a_q <= '0;
            now_b_q <= '0;
          end
          dsrp_pkg::OP_TICK: begin
            ramp_count_q <= adjust ? 16'd0 : rc_inc;
            if (adjust) begin
              now_a_q <= na;
              now_b_q <= nb;
            end
            if (changed) begin
              if (na > 0)      dir_a_q <= 1'b1;
              else if (na < 0) dir_a_q <= 1'b0;
              if (nb < 0)      dir_b_q <= 1'b1;
              else if (nb > 0) dir_b_q <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.per_wr) begin
        if (cmd_i.sel) period_b_q <= per_val;
        else           period_a_q <= per_val;
      end
      if (cmd_i.count) begin
        cnt_a_q <= cnt_a_d;
        cnt_b_q <= cnt_b_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= {15'b0, spr_q} * {13'b0, mag_c};
    if (cmd_i.rate_ld) rate_q <= rate_d;
    if (cmd_i.out_load) begin
      out_q <= {disabled_nx, dir_b_q, dir_a_q,
                step_b & cmd_i.count, step_a & cmd_i.count};
    end
  end

  always_comb begin
    st_o.tick      = (op == dsrp_pkg::OP_TICK);
    st_o.changed   = changed;
    st_o.div_done  = div_done;
    st_o.rate_zero = rate_zero;
  end

  assign out_o = out_q;

endmodule

// ===== hdl/dsrp_ctrl.sv =====
`timescale 1ns / 1ps

module dsrp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dsrp_pkg::status_t st_i,
  output dsrp_pkg::cmd_t    cmd_o
);

  dsrp_pkg::ctrl_state_e state_q, state_d;
  logic sel_q, sel_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dsrp_pkg::ST_IDLE: begin
        if (in_valid_i && out_free && st_i.tick && st_i.changed) state_d = dsrp_pkg::ST_MUL;
      end
      dsrp_pkg::ST_MUL:  state_d = dsrp_pkg::ST_RATE;
      dsrp_pkg::ST_RATE: state_d = dsrp_pkg::ST_RATE_CHK;
      dsrp_pkg::ST_RATE_CHK: begin
        if (!st_i.rate_zero) state_d = dsrp_pkg::ST_PER_WAIT;
        else if (sel_q)      state_d = dsrp_pkg::ST_COUNT;
        else                 state_d = dsrp_pkg::ST_MUL;
      end
      dsrp_pkg::ST_PER_WAIT: begin
        if (st_i.div_done) state_d = sel_q ? dsrp_pkg::ST_COUNT : dsrp_pkg::ST_MUL;
      end
      dsrp_pkg::ST_COUNT: begin
        if (out_free) state_d = dsrp_pkg::ST_IDLE;
      end
      default: state_d = dsrp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dsrp_pkg::ST_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          cmd_o.accept = 1'b1;
          if (!(st_i.tick && st_i.changed)) begin
            cmd_o.out_load = 1'b1;
            cmd_o.count    = st_i.tick;
          end
        end
      end
      dsrp_pkg::ST_MUL:  cmd_o.mul = 1'b1;
      dsrp_pkg::ST_RATE: cmd_o.rate_ld = 1'b1;
      dsrp_pkg::ST_RATE_CHK: begin
        // zero rate: no division, the period is cleared
        if (st_i.rate_zero) cmd_o.per_wr    = 1'b1;
        else                cmd_o.div_start = 1'b1;
      end
      dsrp_pkg::ST_PER_WAIT: begin
        if (st_i.div_done) cmd_o.per_wr = 1'b1;
      end
      dsrp_pkg::ST_COUNT: begin
        if (out_free) begin
          cmd_o.count    = 1'b1;
          cmd_o.out_load = 1'b1;
        end
      end
      default: ;
    endcase
    cmd_o.sel = sel_q;
  end

  always_comb begin
    sel_d = sel_q;
    if (cmd_o.accept)      sel_d = 1'b0;
    else if (cmd_o.per_wr) sel_d = 1'b1;
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)    out_valid_d = 1'b1;
    else if (out_ready_i)  out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsrp_pkg::ST_IDLE;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/dual_stepper_ramp_pulse_gen.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata goals, tuser op
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata step and line flags
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One result word per input word. A word that changes no speed loads its result
// as it is accepted. A tick that changes a speed runs, per motor, A before B, the
// product, the reciprocal multiply for /1000, a check and a 16-step serial
// division of 50000 by the rate (none if its rate is zero), then a count step.
// Reset is asynchronous, active low; registers with a reset restart at their default values.
// A stalled result holds the output register; input is refused until it is taken.

module dual_stepper_ramp_pulse_gen (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] goal_a, [31:16] goal_b
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] step_a, [1] step_b, [2] dir_a, [3] dir_b,
                                      // [4] enable_low, [7:5] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  dsrp_pkg::cmd_t    cmd;
  dsrp_pkg::status_t st;
  logic [4:0]        out;

  dsrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  dsrp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_i        (s_axis_tuser),
    .goal_a_i    (s_axis_tdata[15:0]),
    .goal_b_i    (s_axis_tdata[31:16]),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_o       (out)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {3'b000, out};

endmodule

// ===== hdl/dsrp_checker.sv =====
`timescale 1ns / 1ps

module dsrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [15:0] cfg_data_i
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // no input taken while a result is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("input accepted over a pending result");

  // disable answers next cycle, no steps, line high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == dsrp_pkg::OP_DISABLE
    |=> m_axis_tvalid && m_axis_tdata[4] && m_axis_tdata[1:0] == 2'b00)
    else $error("disable word result wrong");

  // enable answers next cycle, no steps, line low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == dsrp_pkg::OP_ENABLE
    |=> m_axis_tvalid && !m_axis_tdata[4] && m_axis_tdata[1:0] == 2'b00)
    else $error("enable word result wrong");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000)
    else $error("result padding bits set");

endmodule

bind dual_stepper_ramp_pulse_gen dsrp_checker u_dsrp_checker (.*);

// ===== dv/tb_dual_stepper_ramp_pulse_gen.sv =====
`timescale 1ns / 1ps

module tb_dual_stepper_ramp_pulse_gen;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 200;

  // result word layout, lowest bit last
  typedef struct packed {
    logic [2:0] pad;
    logic       enable_low;
    logic       dir_b;
    logic       dir_a;
    logic       step_b;
    logic       step_a;
  } flags_t;

  // Tracks both channels tick by tick and holds the flag words still owed by the block.
  class pulse_model;
    logic [15:0] ramp_div;
    logic [14:0] ramp_stp;
    logic [14:0] max_spd;
    logic [12:0] spr;
    logic [15:0] ramp_cnt;
    int          speed_a, speed_b, goal_a, goal_b;
    logic [15:0] per_a, per_b;
    logic [16:0] cnt_a, cnt_b;
    logic        dir_a, dir_b, disabled;
    flags_t      pending_flags[$];
    int unsigned mismatches, results, pulses;

    function new();
      ramp_div   = dsrp_pkg::RampDivRst;
      ramp_stp   = dsrp_pkg::RampStpRst;
      max_spd    = dsrp_pkg::MaxSpdRst;
      spr        = dsrp_pkg::SprRst;
      ramp_cnt   = '0;
      speed_a    = 0;
      speed_b    = 0;
      goal_a     = 0;
      goal_b     = 0;
      per_a      = '0;
      per_b      = '0;
      cnt_a      = '0;
      cnt_b      = '0;
      dir_a      = 1'b0;
      dir_b      = 1'b0;
      disabled   = 1'b0;
      mismatches = 0;
      results    = 0;
      pulses     = 0;
    endfunction

    function void set_reg(dsrp_pkg::cfg_idx_e idx, logic [15:0] val);
      case (idx)
        dsrp_pkg::CFG_RAMP_DIVIDER:  ramp_div = val;
        dsrp_pkg::CFG_RAMP_STEP:     ramp_stp = val[14:0];
        dsrp_pkg::CFG_MAX_SPEED:     max_spd  = val[14:0];
        dsrp_pkg::CFG_STEPS_PER_REV: spr      = val[12:0];
        default: ;
      endcase
    endfunction

    // one ramp move, stopping on the goal
    function int approach(int now, int goal);
      int s;
      s = int'(ramp_stp);
      if (now < goal) begin
        now += s;
        if (now > goal) now = goal;
      end else if (now > goal) begin
        now -= s;
        if (now < goal) now = goal;
      end
      return now;
    endfunction

    function logic [15:0] period_for(int speed);
      int unsigned mag, rate, p;
      mag = (speed < 0) ? -speed : speed;
      if (mag > max_spd) mag = max_spd;
      rate = spr * mag / 1000;
      if (rate == 0) return '0;
      p = (1000000 / rate) / 20;
      if (p > 65535) p = 65535;
      return p[15:0];
    endfunction

    // idle channel parks its counter at -1
    function logic count_step(inout logic [16:0] cnt, input logic [15:0] per);
      if (per == '0) begin
        cnt = '1;
        return 1'b0;
      end
      cnt = cnt + 17'd1;
      if ($signed(cnt) >= $signed({1'b0, per})) begin
        cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void apply_word(dsrp_pkg::op_e op, logic [15:0] ga, logic [15:0] gb);
      flags_t f;
      int     na, nb;
      f = '0;
      case (op)
        dsrp_pkg::OP_SET_GOALS: begin
          goal_a = int'($signed(ga));
          goal_b = int'($signed(gb));
        end
        dsrp_pkg::OP_ENABLE: disabled = 1'b0;
        dsrp_pkg::OP_DISABLE: begin
          disabled = 1'b1;
          speed_a  = 0;
          speed_b  = 0;
        end
        default: begin
          if (ramp_cnt != 16'hFFFF) ramp_cnt++;
          if (ramp_cnt >= ramp_div) begin
            na = approach(speed_a, goal_a);
            nb = approach(speed_b, goal_b);
            if (na != speed_a || nb != speed_b) begin
              if (na > 0) dir_a = 1'b1;
              else if (na < 0) dir_a = 1'b0;
              // motor B is mounted mirrored
              if (nb < 0) dir_b = 1'b1;
              else if (nb > 0) dir_b = 1'b0;
              per_a = period_for(na);
              per_b = period_for(nb);
            end
            speed_a  = na;
            speed_b  = nb;
            ramp_cnt = '0;
          end
          f.step_a = count_step(cnt_a, per_a);
          f.step_b = count_step(cnt_b, per_b);
        end
      endcase
      f.dir_a      = dir_a;
      f.dir_b      = dir_b;
      f.enable_low = disabled;
      pending_flags.push_back(f);
    endfunction

    function void check_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_flags(flags_t got);
      flags_t want;
      results++;
      pulses += got.step_a + got.step_b;
      if (pending_flags.size() == 0) begin
        $error("result word %h arrived with nothing outstanding", got);
        mismatches++;
        return;
      end
      want = pending_flags.pop_front();
      check_field("step_a", 3'(want.step_a), 3'(got.step_a));
      check_field("step_b", 3'(want.step_b), 3'(got.step_b));
      check_field("dir_a", 3'(want.dir_a), 3'(got.dir_a));
      check_field("dir_b", 3'(want.dir_b), 3'(got.dir_b));
      check_field("enable_low", 3'(want.enable_low), 3'(got.enable_low));
      check_field("pad", want.pad, got.pad);
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  pulse_model  model;
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned settings   = 0;
  int unsigned cycle_count = 0;

  dual_stepper_ramp_pulse_gen dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles, %0d words outstanding", cycle_count,
               model.pending_flags.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk_i) m_axis_tready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) model.check_flags(m_axis_tdata);
  end

  // all tasks start and end on a falling edge
  task automatic push_word(dsrp_pkg::op_e op, logic [15:0] ga, logic [15:0] gb);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {gb, ga};
    do @(posedge clk_i); while (!s_axis_tready);
    model.apply_word(op, ga, gb);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (model.pending_flags.size() != 0) @(negedge clk_i);
  endtask

  task automatic load_reg(dsrp_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    model.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic program_regs(logic [15:0] div, logic [15:0] stp, logic [15:0] mx,
                              logic [15:0] sp);
    wait_drained();
    load_reg(dsrp_pkg::CFG_RAMP_DIVIDER, div);
    load_reg(dsrp_pkg::CFG_RAMP_STEP, stp);
    load_reg(dsrp_pkg::CFG_MAX_SPEED, mx);
    load_reg(dsrp_pkg::CFG_STEPS_PER_REV, sp);
    settings++;
  endtask

  // mostly modest speeds so periods stay short enough to see pulses
  function automatic logic [15:0] pick_goal();
    int mag;
    case ($urandom_range(3))
      0: return 16'($urandom);
      1, 2: mag = $urandom_range(3000);
      default: mag = $urandom_range(300);
    endcase
    return ($urandom_range(1) != 0) ? 16'(-mag) : 16'(mag);
  endfunction

  task automatic run_phase(logic [15:0] div, logic [15:0] stp, logic [15:0] mx,
                           logic [15:0] sp, int words, int mode);
    int unsigned r;
    program_regs(div, stp, mx, sp);
    case (mode)
      1:       begin gap_pct = 46; stall_pct = 0;  end
      2:       begin gap_pct = 0;  stall_pct = 46; end
      3:       begin gap_pct = 14; stall_pct = 14; end
      default: begin gap_pct = 0;  stall_pct = 0;  end
    endcase
    push_word(dsrp_pkg::OP_ENABLE, pick_goal(), pick_goal());
    for (int i = 0; i < words; i++) begin
      // hold off mid-phase until the block has caught up
      if (i == words / 2) wait_drained();
      r = $urandom_range(99);
      if (r < 74) push_word(dsrp_pkg::OP_TICK, 16'($urandom), 16'($urandom));
      else if (r < 88) push_word(dsrp_pkg::OP_SET_GOALS, pick_goal(), pick_goal());
      else if (r < 95) push_word(dsrp_pkg::OP_ENABLE, 16'($urandom), 16'($urandom));
      else push_word(dsrp_pkg::OP_DISABLE, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    model = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: ramp past max_speed, disable mid-ramp, back to zero, tiny speeds
    program_regs(16'd1, 16'd4000, 16'd20000, 16'd200);
    push_word(dsrp_pkg::OP_TICK, 16'h0000, 16'h0000);
    push_word(dsrp_pkg::OP_SET_GOALS, 16'h7FFF, 16'h8000);
    push_word(dsrp_pkg::OP_ENABLE, 16'hFFFF, 16'hFFFF);
    repeat (6) push_word(dsrp_pkg::OP_TICK, 16'h0000, 16'h0000);
    push_word(dsrp_pkg::OP_DISABLE, 16'h5555, 16'hAAAA);
    repeat (2) push_word(dsrp_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
    push_word(dsrp_pkg::OP_SET_GOALS, 16'h0000, 16'h0000);
    repeat (2) push_word(dsrp_pkg::OP_TICK, 16'h0000, 16'h0000);
    push_word(dsrp_pkg::OP_SET_GOALS, 16'hFFFF, 16'h0001);
    push_word(dsrp_pkg::OP_TICK, 16'h0000, 16'h0000);
    push_word(dsrp_pkg::OP_ENABLE, 16'h0000, 16'h0000);
    push_word(dsrp_pkg::OP_TICK, 16'h0000, 16'h0000);

    run_phase(16'd1, 16'd32767, 16'd32767, 16'd4096, 240, 0);
    run_phase(16'd3, 16'd200, 16'd8000, 16'd1000, 240, 1);
    run_phase(16'd1, 16'd1, 16'd1, 16'd1, 120, 2);
    run_phase(16'd2, 16'd700, 16'd2000, 16'd4096, 240, 3);
    run_phase(16'd65535, 16'd50, 16'd5000, 16'd200, 80, 1);
    run_phase(16'd5, 16'd3000, 16'd32767, 16'd600, 240, 2);
    run_phase(16'd2, 16'd1500, 16'd12000, 16'd2500, 260, 3);

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (model.pending_flags.size() != 0) begin
      $error("%0d result words never arrived", model.pending_flags.size());
      model.mismatches++;
    end

    $display("Sent %0d words under %0d register settings and four idling modes;",
             words_sent, settings);
    $display("checked %0d result words, %0d step pulses among them, %0d mismatches.",
             model.results, model.pulses, model.mismatches);
    if (model.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== dual_stepper_ramp_pulse_gen.f =====
hdl/dsrp_pkg.sv
hdl/dsrp_div.sv
hdl/dsrp_dp.sv
hdl/dsrp_ctrl.sv
hdl/dual_stepper_ramp_pulse_gen.sv
hdl/dsrp_checker.sv
dv/tb_dual_stepper_ramp_pulse_gen.sv
